### rtl/core/sine_tone_generator_defines.svh
// assertion helpers for the sine tone generator
// all checks are clocked on clk_i and held off while rst_ni is low
`ifndef SINE_TONE_GENERATOR_DEFINES_SVH
`define SINE_TONE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define STG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define STG_ASSERT_IMPL(label, ante, cons, msg) \
  `STG_ASSERT(label, (ante) |-> (cons), msg)

`define STG_ASSERT_NEXT(label, ante, cons, msg) \
  `STG_ASSERT(label, (ante) |=> (cons), msg)

`else

`define STG_ASSERT(label, prop, msg)
`define STG_ASSERT_IMPL(label, ante, cons, msg)
`define STG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/stg_pkg.sv
`default_nettype none

package stg_pkg;

  localparam int unsigned SAMPLE_RATE = 44100;
  localparam int unsigned QDEPTH      = 256;

  localparam int TONE_W   = 15;
  localparam int TC_W     = 16;
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 16;
  localparam int VOL_SH   = 15;

  localparam logic [VOL_W-1:0]    VOL_MAX    = VOL_W'(32768);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(32767);

  localparam int QAW    = $clog2(QDEPTH);
  localparam int PW     = QAW + 2;
  localparam int PROD_W = TC_W + TONE_W;
  localparam int SR_W   = $clog2(SAMPLE_RATE);

  localparam logic [SR_W-1:0]   SR_L   = SR_W'(SAMPLE_RATE);
  localparam logic [PROD_W-1:0] SR_P   = PROD_W'(SAMPLE_RATE);

  // prod / SAMPLE_RATE by reciprocal: exact for any PROD_W-bit numerator
  localparam int DIV1_SH = PROD_W + SR_W;
  localparam int M1_W    = PROD_W + 1;
  localparam int Q1_W    = PROD_W - SR_W + 1;
  localparam logic [63:0] M1 =
    ((64'd1 << DIV1_SH) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);

  // (rem * 4 * QDEPTH) / SAMPLE_RATE by reciprocal, exact for rem < SAMPLE_RATE
  localparam int X_W     = SR_W + PW;
  localparam int DIV2_SH = X_W + SR_W;
  localparam int M2_W    = X_W + 1;
  localparam logic [63:0] M2 =
    ((64'd1 << DIV2_SH) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [SAMPLE_W-1:0] sine_rom_t [QDEPTH];

  typedef struct packed {
    logic           done;
    logic [QAW-1:0] addr;
    logic           full;
    logic           neg;
  } phase_res_t;

  // exact unsigned quotient by shift and subtract, elaboration only
  function automatic longint unsigned udiv_const(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | 64'(num[b]);
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave entry, evaluated at elaboration only
  function automatic logic [SAMPLE_W-1:0] quarter_sine(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint          sum;
    longint          scaled;
    // 2 * QDEPTH is a power of two
    x    = (PI_Q30 * longint'(i)) >> (QAW + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      div  = longint'((2 * k) * (2 * k + 1));
      term = (term * x2) >> 30;
      term = udiv_const(term, div);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    scaled = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (scaled > 32767) scaled = 32767;
    return SAMPLE_W'(scaled);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int unsigned i = 0; i < QDEPTH; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### rtl/core/stg_ram.sv
`default_nettype none

module stg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/stg_phase.sv
`default_nettype none

module stg_phase
  import stg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TC_W-1:0]   tc_i,
  input  wire logic [TONE_W-1:0] tone_i,
  output phase_res_t             res_o
);

  localparam int NSTG = 6;
  localparam int W1   = PROD_W + M1_W;
  localparam int WQD  = Q1_W + SR_W;
  localparam int W2   = X_W + M2_W;

  logic [NSTG-1:0]   vld_q;
  logic [PROD_W-1:0] prod_q;
  logic [W1-1:0]     m1_q;
  logic [PROD_W-1:0] qd_q;
  logic [SR_W-1:0]   rem_q;
  logic [W2-1:0]     m2_q;
  logic [QAW-1:0]    addr_q;
  logic              full_q;
  logic              neg_q;

  logic [Q1_W-1:0]   quot;
  logic [WQD-1:0]    qd_full;
  logic [PROD_W-1:0] rem_full;
  logic [X_W-1:0]    x;
  logic [PW-1:0]     p;
  logic [1:0]        quad;
  logic [QAW-1:0]    r;

  assign quot     = m1_q[DIV1_SH +: Q1_W];
  assign qd_full  = WQD'(quot) * WQD'(SR_L);
  assign rem_full = prod_q - qd_q;
  assign x        = {rem_q, {PW{1'b0}}};
  assign p        = m2_q[DIV2_SH +: PW];
  assign quad     = p[PW-1 -: 2];
  assign r        = p[QAW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(tc_i) * PROD_W'(tone_i);
    end
    m1_q  <= W1'(prod_q) * W1'(M1_W'(M1));
    qd_q  <= PROD_W'(qd_full);
    rem_q <= SR_W'(rem_full);
    m2_q  <= W2'(x) * W2'(M2_W'(M2));
    // odd quadrants run the table backwards, the quarter point itself is full scale
    full_q <= quad[0] && (r == '0);
    addr_q <= quad[0] ? (QAW'(0) - r) : r;
    neg_q  <= quad[1];
  end

  assign res_o.done = vld_q[NSTG-1];
  assign res_o.addr = addr_q;
  assign res_o.full = full_q;
  assign res_o.neg  = neg_q;

endmodule

`default_nettype wire

### rtl/core/sine_tone_generator.sv
// sine tone generator, one output beat per input beat
// each beat passes ST_STEP, the 6-stage phase divider in ST_PHASE, the table
//   read and the gain multiply; output tvalid rises once ST_SCALE can load the
//   output register, and no new beat is taken until then: one item in flight
// reset: tone and time state and volume clear to zero, then a sweep writes all
//   256 quarter-wave table ram entries; no input beat is taken meanwhile
`default_nettype none
`include "sine_tone_generator_defines.svh"

module sine_tone_generator
  import stg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [VOL_W-1:0]    cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,   // [14:0] requested_tone
  input  wire logic [1:0]          s_axis_tuser,   // [0] reload_tone, [1] restart
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [SAMPLE_W-1:0]      m_axis_tdata    // [15:0] sample
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_STEP,
    ST_PHASE,
    ST_READ,
    ST_SCALE
  } state_e;

  localparam int GAIN_W = SAMPLE_W + VOL_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  state_e              state_q;
  logic [TONE_W-1:0]   pending_q;
  logic [TONE_W-1:0]   active_q;
  logic [TC_W-1:0]     tc_q;
  logic [QAW-1:0]      init_cnt_q;
  logic                full_q;
  logic                neg_q;
  logic [GAIN_W-1:0]   gain_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;
  logic [VOL_W-1:0]    volume_q;

  logic                accept;
  logic [TONE_W-1:0]   req;
  logic [TONE_W-1:0]   pend_n;
  logic [TONE_W-1:0]   act_n;
  logic [TC_W-1:0]     tc_n;
  logic [TC_W-1:0]     tc_inc;
  logic                period_end;
  logic [PROD_W-1:0]   tone_prod;
  phase_res_t          ph;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] wave;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] sample;
  logic                out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // this beat's updates: pending first, then restart, then reload
  assign req    = s_axis_tdata[TONE_W-1:0];
  assign pend_n = (req != '0) ? req : pending_q;
  assign tc_n   = s_axis_tuser[1] ? '0 : tc_q;
  assign act_n  = s_axis_tuser[0] ? pend_n : active_q;

  assign tc_inc     = tc_q + TC_W'(1);
  assign period_end = (PROD_W'(tc_inc) * PROD_W'(active_q)) > SR_P;
  assign tone_prod  = PROD_W'(tc_q) * PROD_W'(active_q);

  stg_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .tc_i   (tc_n),
    .tone_i (act_n),
    .res_o  (ph)
  );

  assign ram_re = (state_q == ST_PHASE) && ph.done;

  stg_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(QDEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_INIT),
    .waddr_i(init_cnt_q),
    .wdata_i(SINE_ROM[init_cnt_q]),
    .re_i   (ram_re),
    .raddr_i(ph.addr),
    .rdata_o(ram_rdata)
  );

  assign wave     = full_q ? FULL_SCALE : ram_rdata;
  assign mag      = gain_q[VOL_SH +: SAMPLE_W];
  assign sample   = neg_q ? (SAMPLE_W'(0) - mag) : mag;
  assign out_load = (state_q == ST_SCALE) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= '0;
    end else if (cfg_we_i && (cfg_wdata_i <= VOL_MAX)) begin
      volume_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      pending_q   <= '0;
      active_q    <= '0;
      tc_q        <= '0;
      init_cnt_q  <= '0;
      full_q      <= 1'b0;
      neg_q       <= 1'b0;
      gain_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= sample;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          init_cnt_q <= init_cnt_q + QAW'(1);
          if (init_cnt_q == QAW'(QDEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            pending_q <= pend_n;
            active_q  <= act_n;
            tc_q      <= tc_n;
            state_q   <= ST_STEP;
          end
        end
        ST_STEP: begin
          // divider already holds this beat's product, so the tick can advance
          if (period_end) begin
            tc_q     <= '0;
            active_q <= pending_q;
          end else begin
            tc_q <= tc_inc;
          end
          state_q <= ST_PHASE;
        end
        ST_PHASE: begin
          if (ph.done) begin
            full_q  <= ph.full;
            neg_q   <= ph.neg;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          gain_q  <= GAIN_W'(wave) * GAIN_W'(volume_q);
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `STG_ASSERT_NEXT(a_one_in_flight, accept, !s_axis_tready, "second beat taken while busy")
  `STG_ASSERT_IMPL(a_done_in_phase, ph.done, state_q == ST_PHASE, "phase result out of step")
  `STG_ASSERT_NEXT(a_tick_in_period, state_q == ST_STEP, tone_prod <= SR_P, "tick past period end")
  `STG_ASSERT_IMPL(a_sample_range, m_axis_tvalid, m_axis_tdata != SAMPLE_MIN, "sample out of range")

endmodule

`default_nettype wire
